FILE: hdl/rmvn_pkg.sv
// ----------------------------------------------------------------------------
// Running mean / variance normalizer package
// Operation codes and the fixed field widths shared by the normalizer files.
// ----------------------------------------------------------------------------
package rmvn_pkg;

   localparam int SAMPLE_W    = 48;
   localparam int NORM_W      = 32;
   localparam int SUM_W       = 64;
   localparam int OUT_COUNT_W = 32;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_UPDATE    = 2'd0;
   localparam logic [OP_W-1:0] OP_NORMALIZE = 2'd1;
   localparam logic [OP_W-1:0] OP_BOTH      = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

endpackage

FILE: hdl/rmvn_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvn_div #(
   parameter int DVD_W = 65,
   parameter int DSR_W = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [DSR_W-1:0]     divisor,
   output logic                 done,
   output logic [DVD_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DSR_W:0]   rem_sh;
   logic [DSR_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      fits    = rem_sh >= {1'b0, dsr_ff};
      rem_in  = fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_in  = {quo_ff[DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/running_mean_variance_normalizer.sv
// ----------------------------------------------------------------------------
// Running mean / variance normalizer
// Welford statistics over a sample stream with an optional z-score result.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and each gives one result. An update
// runs the serial mean divide and the 49-step shift-add product, a normalize
// the variance divide, the serial square root and the deviation divide. All
// three divides share the one serial divider, DVD_W = max(64, 49+FRAC_BITS)
// bits wide. A new transaction is taken while the previous result still waits
// in the output register.
module running_mean_variance_normalizer #(
   parameter int FRAC_BITS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rmvn_pkg::SAMPLE_W-1:0] req_tdata,  // sample
   input  logic [rmvn_pkg::OP_W-1:0]     req_tuser,  // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,  // norm_value, sample_count
   output logic                          rsp_tuser   // spread_zero
);

   import rmvn_pkg::*;

   localparam int DEV_W  = SAMPLE_W + 1;
   localparam int PROD_W = 2 * DEV_W;
   localparam int DVD_W  = (DEV_W + FRAC_BITS > SUM_W) ? DEV_W + FRAC_BITS : SUM_W;
   localparam int DSR_W  = SUM_W;
   localparam int RAD_W  = ((SUM_W + FRAC_BITS + 1) / 2) * 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SREM_W = ROOT_W + 2;
   localparam int CNT_W  = $clog2(DEV_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_UPD_START, S_UPD_DIV, S_UPD_D2, S_UPD_MUL, S_UPD_ACC,
      S_NRM_CHK, S_VAR_DIV, S_SQRT, S_Z_START, S_Z_DIV, S_DONE
   } state_type;

   state_type                   state_ff;
   logic [OP_W-1:0]             op_ff;
   logic signed [SAMPLE_W-1:0]  x_ff;
   logic [COUNT_WIDTH-1:0]      count_ff;
   logic signed [SAMPLE_W-1:0]  mean_ff;
   logic [SUM_W-1:0]            m2_ff;
   logic signed [DEV_W-1:0]     d1_ff;
   logic [DEV_W-1:0]            mul_a_ff;
   logic [DEV_W-1:0]            mul_b_ff;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [RAD_W-1:0]            rad_ff;
   logic [SREM_W-1:0]           srem_ff, srem_in;
   logic [ROOT_W-1:0]           root_ff, root_in;
   logic                        neg_ff;
   logic [NORM_W-1:0]           z_ff;
   logic                        flat_ff;
   logic [DVD_W-1:0]            dvd_ff;
   logic [DSR_W-1:0]            dsr_ff;
   logic                        rsp_valid_ff;
   logic [NORM_W-1:0]           rsp_z_ff;
   logic                        rsp_flat_ff;
   logic [OUT_COUNT_W-1:0]      rsp_count_ff;

   logic                        div_start_ff;
   logic                        div_done;
   logic [DVD_W-1:0]            quo;

   logic signed [DEV_W-1:0]     d1_in, dev_now;
   logic [DEV_W-1:0]            dev_mag;
   logic [DEV_W-1:0]            q_dev;
   logic signed [DEV_W-1:0]     mean_in;
   logic [DEV_W:0]              mul_sum;
   logic [SUM_W-1:0]            add_val;
   logic [SUM_W:0]              m2_sum;
   logic [SREM_W-1:0]           srem_sh, trial;
   logic                        sat;
   logic                        out_free;

   rmvn_div #(.DVD_W(DVD_W), .DSR_W(DSR_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dvd_ff),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      d1_in   = {req_tdata[SAMPLE_W-1], req_tdata} - {mean_ff[SAMPLE_W-1], mean_ff};
      dev_now = {x_ff[SAMPLE_W-1], x_ff} - {mean_ff[SAMPLE_W-1], mean_ff};
      dev_mag = dev_now[DEV_W-1] ? DEV_W'(-dev_now) : DEV_W'(dev_now);
      q_dev   = quo[DEV_W-1:0];
      mean_in = d1_ff[DEV_W-1] ? {mean_ff[SAMPLE_W-1], mean_ff} - q_dev
                               : {mean_ff[SAMPLE_W-1], mean_ff} + q_dev;
      mul_sum = {1'b0, prod_ff[PROD_W-1:DEV_W]} + (mul_b_ff[0] ? {1'b0, mul_a_ff} : '0);
      prod_in = {mul_sum, prod_ff[DEV_W-1:1]};
      if (|prod_ff[PROD_W-1:SUM_W+FRAC_BITS]) begin
         add_val = '1;
      end else begin
         add_val = prod_ff[SUM_W+FRAC_BITS-1:FRAC_BITS];
      end
      m2_sum  = {1'b0, m2_ff} + {1'b0, add_val};
      srem_sh = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {root_ff, 2'b01};
      if (srem_sh >= trial) begin
         srem_in = srem_sh - trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         srem_in = srem_sh;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
      sat      = |quo[DVD_W-1:NORM_W];
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         mean_ff       <= '0;
         m2_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= req_tuser;
                  x_ff    <= req_tdata;
                  d1_ff   <= d1_in;
                  z_ff    <= '0;
                  flat_ff <= 1'b0;
                  if (req_tuser == OP_UPDATE || req_tuser == OP_BOTH) begin
                     if (count_ff != '1) begin
                        count_ff <= count_ff + 1'b1;
                     end
                     state_ff <= S_UPD_START;
                  end else if (req_tuser == OP_NORMALIZE) begin
                     state_ff <= S_NRM_CHK;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_UPD_START: begin
               dvd_ff       <= DVD_W'(d1_ff[DEV_W-1] ? DEV_W'(-d1_ff) : DEV_W'(d1_ff));
               dsr_ff       <= DSR_W'(count_ff);
               div_start_ff <= 1'b1;
               state_ff     <= S_UPD_DIV;
            end
            S_UPD_DIV: begin
               if (div_done) begin
                  mean_ff  <= mean_in[SAMPLE_W-1:0];
                  state_ff <= S_UPD_D2;
               end
            end
            S_UPD_D2: begin
               mul_a_ff <= d1_ff[DEV_W-1] ? DEV_W'(-d1_ff) : DEV_W'(d1_ff);
               mul_b_ff <= dev_mag;
               prod_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= S_UPD_MUL;
            end
            S_UPD_MUL: begin
               prod_ff  <= prod_in;
               mul_b_ff <= mul_b_ff >> 1;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DEV_W - 1)) begin
                  state_ff <= S_UPD_ACC;
               end
            end
            S_UPD_ACC: begin
               m2_ff    <= m2_sum[SUM_W] ? '1 : m2_sum[SUM_W-1:0];
               state_ff <= (op_ff == OP_BOTH) ? S_NRM_CHK : S_DONE;
            end
            S_NRM_CHK: begin
               if (count_ff < COUNT_WIDTH'(2) || m2_ff == '0) begin
                  flat_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  dvd_ff       <= DVD_W'(m2_ff);
                  dsr_ff       <= DSR_W'(count_ff - 1'b1);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_VAR_DIV;
               end
            end
            S_VAR_DIV: begin
               if (div_done) begin
                  rad_ff   <= RAD_W'({quo[SUM_W-1:0], {FRAC_BITS{1'b0}}});
                  srem_ff  <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               srem_ff <= srem_in;
               root_ff <= root_in;
               rad_ff  <= rad_ff << 2;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
                  state_ff <= S_Z_START;
               end
            end
            S_Z_START: begin
               if (root_ff == '0) begin
                  flat_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  neg_ff       <= dev_now[DEV_W-1];
                  dvd_ff       <= DVD_W'({dev_mag, {FRAC_BITS{1'b0}}});
                  dsr_ff       <= DSR_W'(root_ff);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_Z_DIV;
               end
            end
            S_Z_DIV: begin
               if (div_done) begin
                  if (neg_ff) begin
                     if (sat || quo[NORM_W-1:0] > {1'b1, {(NORM_W-1){1'b0}}}) begin
                        z_ff <= {1'b1, {(NORM_W-1){1'b0}}};
                     end else begin
                        z_ff <= -quo[NORM_W-1:0];
                     end
                  end else begin
                     if (sat || quo[NORM_W-1]) begin
                        z_ff <= {1'b0, {(NORM_W-1){1'b1}}};
                     end else begin
                        z_ff <= quo[NORM_W-1:0];
                     end
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_z_ff     <= z_ff;
                  rsp_flat_ff  <= flat_ff;
                  rsp_count_ff <= OUT_COUNT_W'(count_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_z_ff};
   assign rsp_tuser  = rsp_flat_ff;

   // The divider only finishes while the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_UPD_DIV || state_ff == S_VAR_DIV ||
                    state_ff == S_Z_DIV))
      else $error("divider finished outside a divide step");

   assert property (@(posedge clock) disable iff (reset)
      !reset |=> count_ff >= $past(count_ff))
      else $error("sample count went down");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flat_ff |-> rsp_z_ff == '0)
      else $error("zero spread result carries a nonzero z-score");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_z_ff))
      else $error("pending result changed before it was taken");

endmodule

FILE: tb/rmvn_checker.sv
// ----------------------------------------------------------------------------
// Running mean / variance normalizer checker
// Watches both channels, predicts each result from the accepted requests
// with its own Welford statistics, and compares field by field.
// ----------------------------------------------------------------------------
module rmvn_checker #(
   parameter int FRAC_BITS   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending
);
   import rmvn_pkg::*;

   typedef struct {
      logic [31:0] norm_value;
      logic        spread_zero;
      logic [31:0] sample_count;
   } norm_result_type;

   localparam logic [63:0] CNT_MAX = (65'd1 << COUNT_WIDTH) - 65'd1;

   norm_result_type result_fifo[$];
   logic [63:0]        stat_count;
   logic signed [47:0] stat_mean;
   logic [63:0]        stat_m2;

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Bitwise floor square root of a 128-bit radicand.
   function automatic logic [63:0] floor_sqrt(input logic [127:0] w);
      logic [65:0] rem;
      logic [65:0] trial;
      logic [63:0] root;
      rem = 0;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | w[2*i +: 2];
         root = root << 1;
         trial = {root, 1'b1};
         if (rem >= trial) begin
            rem = rem - trial;
            root[0] = 1'b1;
         end
      end
      return root;
   endfunction

   task automatic apply_update(input logic signed [63:0] x);
      logic signed [63:0] d1, d2;
      logic [63:0] q;
      logic [127:0] prod, add;
      logic [64:0] sum;
      if (stat_count < CNT_MAX) stat_count = stat_count + 1;
      d1 = x - stat_mean;
      q = magnitude(d1) / stat_count;
      stat_mean = stat_mean + (d1 < 0 ? -$signed(q) : $signed(q));
      d2 = x - stat_mean;
      prod = magnitude(d1) * magnitude(d2);
      add = prod >> FRAC_BITS;
      if (add[127:64] != 0) add = 128'hFFFF_FFFF_FFFF_FFFF;
      sum = stat_m2 + add[63:0];
      stat_m2 = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
   endtask

   task automatic compute_zscore(input logic signed [63:0] x, output logic [31:0] z,
                                 output logic flat);
      logic [63:0] variance, sd, dm;
      logic [127:0] quo;
      logic signed [63:0] dev;
      z = 0;
      flat = 1;
      if (stat_count < 2 || stat_m2 == 0) return;
      variance = stat_m2 / (stat_count - 1);
      sd = floor_sqrt({64'd0, variance} << FRAC_BITS);
      if (sd == 0) return;
      dev = x - stat_mean;
      dm = magnitude(dev);
      quo = ({64'd0, dm} << FRAC_BITS) / sd;
      if (dev < 0) begin
         if (quo > 128'h8000_0000) quo = 128'h8000_0000;
         z = -quo[31:0];
      end else begin
         if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
         z = quo[31:0];
      end
      flat = 0;
   endtask

   always @(posedge clock) begin
      norm_result_type exp_r, got;
      logic signed [63:0] x;
      int errs;
      errs = 0;
      if (reset) begin
         stat_count = 0;
         stat_mean  = 0;
         stat_m2    = 0;
         fail_count <= 0;
         result_fifo.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            x = $signed(req_tdata);
            exp_r.norm_value = 0;
            exp_r.spread_zero = 0;
            if (req_tuser == OP_UPDATE || req_tuser == OP_BOTH) apply_update(x);
            if (req_tuser == OP_NORMALIZE || req_tuser == OP_BOTH)
               compute_zscore(x, exp_r.norm_value, exp_r.spread_zero);
            exp_r.sample_count = stat_count[31:0];
            result_fifo.push_back(exp_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.norm_value = rsp_tdata[31:0];
            got.sample_count = rsp_tdata[63:32];
            got.spread_zero = rsp_tuser;
            if (result_fifo.size() == 0) begin
               $error("unexpected result transaction");
               errs++;
            end else begin
               exp_r = result_fifo.pop_front();
               if (got.norm_value !== exp_r.norm_value) begin
                  $error("norm_value expected %h actual %h", exp_r.norm_value, got.norm_value);
                  errs++;
               end
               if (got.spread_zero !== exp_r.spread_zero) begin
                  $error("spread_zero expected %b actual %b", exp_r.spread_zero,
                         got.spread_zero);
                  errs++;
               end
               if (got.sample_count !== exp_r.sample_count) begin
                  $error("sample_count expected %0d actual %0d", exp_r.sample_count,
                         got.sample_count);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
      pending = result_fifo.size();
   end
endmodule

FILE: tb/tb_running_mean_variance_normalizer.sv
// ----------------------------------------------------------------------------
// Running mean / variance normalizer testbench
// Drives directed and random sample streams under several idling phases and
// a long output stall; the checker compares every result.
// ----------------------------------------------------------------------------
module tb_running_mean_variance_normalizer;
   import rmvn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = 0;   // sample
   logic [1:0]  req_tuser = 0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;       // norm_value, sample_count
   logic        rsp_tuser;       // spread_zero
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          long_hold = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   running_mean_variance_normalizer DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   rmvn_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .fail_count, .pending
   );

   // Receiver: random stalls, or a long hold-off counted in cycles.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (long_hold) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // The valid line stays high from one accepted transaction to the next
   // unless the sender idles in between.
   task automatic send(input logic [1:0] op, input logic [47:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [47:0] rand_sample();
      logic [47:0] s;
      case ($urandom_range(5))
         0: s = 48'({$urandom, $urandom});
         1: s = $signed(48'($signed($urandom_range(2000)) - 1000)) <<< 16;
         2: s = 48'($signed($urandom_range(200)) - 100);
         3: s = $urandom_range(1) ? 48'h7FFF_FFFF_FFFF - $urandom_range(3)
                                  : 48'h8000_0000_0000 + $urandom_range(3);
         default: s = 48'($signed($urandom_range(65536)) - 32768) <<< 8;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] rand_op();
      int r;
      r = $urandom_range(9);
      if (r < 4) return OP_UPDATE;
      if (r < 6) return OP_NORMALIZE;
      if (r < 9) return OP_BOTH;
      return OP_UNUSED;
   endfunction

   initial begin
      int hold_cycles;
      repeat (5) @(posedge clock);
      reset <= 0;
      // Too few samples, then constant samples with no spread.
      send(OP_NORMALIZE, 48'h0000_0001_0000);
      send(OP_BOTH, 48'h0000_0001_0000);
      send(OP_BOTH, 48'h0000_0001_0000);
      send(OP_UPDATE, 48'h0000_0001_0000);
      send(OP_NORMALIZE, 48'h0000_0002_0000);
      send(OP_UNUSED, 48'h1234_5678_9ABC);
      // Spread grows; extreme samples drive the z-score to saturation.
      send(OP_UPDATE, 48'h0000_0001_0001);
      send(OP_NORMALIZE, 48'h7FFF_FFFF_FFFF);
      send(OP_NORMALIZE, 48'h8000_0000_0000);
      send(OP_BOTH, 48'h7FFF_FFFF_FFFF);
      send(OP_BOTH, 48'h8000_0000_0000);
      send(OP_UPDATE, 48'hFFFF_FFFF_FFFF);
      send(OP_NORMALIZE, 48'h0);
      send(OP_BOTH, 48'hFFFF_0000_0000);
      send(OP_UNUSED, 48'hFFFF_FFFF_FFFF);
      send(OP_NORMALIZE, 48'h5555_5555_5555);
      send(OP_NORMALIZE, 48'hAAAA_AAAA_AAAA);
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 60 : 28) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 60 : 28) : 0;
         for (int i = 0; i < 100; i++) begin
            // Long output hold-off while requests keep coming.
            if (phase == 0 && i == 20) begin
               fork
                  begin
                     long_hold = 1;
                     hold_cycles = 0;
                     while (hold_cycles < 1500) begin
                        @(posedge clock);
                        hold_cycles++;
                     end
                     long_hold = 0;
                  end
               join_none
            end
            send(rand_op(), rand_sample());
         end
      end
      req_tvalid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #6000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
